@@ hw/rtl/art_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the address resolution table
// no dependencies

package art_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int HOLD_LIMIT    = 15;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int HC_W      = $clog2(HOLD_LIMIT + 1);
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 4;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_UPDATED = 2'd1,
        ST_HIT     = 2'd2,
        ST_QUEUED  = 2'd3
    } art_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE
    } art_state_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic        create;
        logic [31:0] now_ms;
    } art_req_t;

    typedef struct packed {
        art_status_t          status;
        logic [IDX_OUT_W-1:0] entry_index;
        logic [47:0]          mac_out;
        logic [CNT_OUT_W-1:0] released_count;
        logic [CNT_OUT_W-1:0] dropped_count;
        logic                 hold_overflow;
    } art_rsp_t;

    // one table entry as kept in the entry memory
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } art_entry_t;

    typedef struct packed {
        logic             clear;
        logic             eval;
        logic [IDX_W-1:0] idx;
        logic             entry_vld;
    } art_scan_ctl_t;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic [47:0]      match_mac;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] old_idx;
    } art_scan_t;

endpackage

@@ hw/rtl/art_req_if.sv @@
`timescale 1ns / 1ps
// request channel: valid/ready handshake with one request payload
// depends on art_pkg

interface art_req_if import art_pkg::*;;
    logic     valid;
    logic     ready;
    art_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/art_rsp_if.sv @@
`timescale 1ns / 1ps
// response channel: valid/ready handshake with one result payload
// depends on art_pkg

interface art_rsp_if import art_pkg::*;;
    logic     valid;
    logic     ready;
    art_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/art_scan.sv @@
`timescale 1ns / 1ps
// table scan tracker: first match, first free entry and oldest entry
// depends on art_pkg

module art_scan import art_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  art_scan_ctl_t ctl,
    input  art_entry_t    entry,
    input  logic [31:0]   key_ip,
    input  logic [31:0]   now_ms,
    output art_scan_t     result
);

    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [47:0]      match_mac_reg, match_mac_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    logic [31:0]      old_age_reg, old_age_next;
    logic [31:0]      age;

    // wrapping age of the entry under evaluation
    assign age = now_ms - entry.stamp;

    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_mac_next   = match_mac_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        old_idx_next     = old_idx_reg;
        old_age_next     = old_age_reg;
        if (ctl.clear)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else if (ctl.eval)
        begin
            if (!match_found_reg && ctl.entry_vld && entry.ip == key_ip)
            begin
                match_found_next = 1'b1;
                match_idx_next   = ctl.idx;
                match_mac_next   = entry.mac;
            end
            if (!free_found_reg && !ctl.entry_vld)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ctl.idx;
            end
            // strict compare keeps the lowest index on a tie
            if (ctl.idx == '0 || age > old_age_reg)
            begin
                old_idx_next = ctl.idx;
                old_age_next = age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_age_reg   <= old_age_next;
    end

    assign result.match_found = match_found_reg;
    assign result.match_idx   = match_idx_reg;
    assign result.match_mac   = match_mac_reg;
    assign result.free_found  = free_found_reg;
    assign result.free_idx    = free_idx_reg;
    assign result.old_idx     = old_idx_reg;

endmodule

@@ hw/rtl/address_resolution_table_core.sv @@
`timescale 1ns / 1ps
// address resolution table top level: entry memory, scan sequencer, result register
// depends on art_pkg, art_req_if, art_rsp_if, art_scan

// usage
// - req carries one transaction per item: update (learned ip/mac mapping) or
//   lookup (ip of an outgoing packet); rsp returns exactly one result per item
// - ip, mac and stamp of every entry live in a single-port-read synchronous
//   memory; valid, resolved and held counts are flip-flops
// - each item reads all TABLE_ENTRIES entries, one per cycle, to find the first
//   match, the first free entry and the oldest entry, then writes back at most once
// - one item in flight: the sequencer steps through its scan, last and decide
//   states and is back in idle, ready for the next request, only once the
//   result is loaded into the result register
// - req.ready is high only while the sequencer is idle
// - the result register decouples rsp: a new request is taken while an
//   earlier result still waits; if rsp stalls with a result held, the next
//   item waits in its decide step until the register frees
// - reset clears valid, resolved and held counts at once; memory contents
//   need no clearing since only valid entries are ever used

module address_resolution_table_core import art_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    art_req_if.sink    req,
    art_rsp_if.source  rsp
);

    // sequencer
    art_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             in_ready;
    logic             rd_en;
    logic             accept;
    logic             res_load;

    // item under work
    art_req_t         item_reg;

    // entry memory
    art_entry_t       mem [TABLE_ENTRIES];
    art_entry_t       rd_data_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             mem_we;
    art_entry_t       wr_data;

    // per-entry flags
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] resolved_reg;
    logic [HC_W-1:0]          held_reg [TABLE_ENTRIES];

    // scan tracker
    art_scan_ctl_t    scan_ctl;
    art_scan_t        scan;

    // decision
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] sel_idx;
    logic             sel_valid;
    logic             sel_resolved;
    logic [HC_W-1:0]  sel_held;
    logic             flag_we;
    logic             flag_valid;
    logic             flag_resolved;
    logic [HC_W-1:0]  flag_held;
    art_rsp_t         res;

    // result register
    logic             rsp_valid_reg, rsp_valid_next;
    art_rsp_t         rsp_data_reg;

    assign accept   = req.valid && in_ready;
    assign res_load = (state_reg == S_DECIDE) && (!rsp_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                    state_next = S_LAST;
            end
            S_LAST:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (res_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_SCAN:   rd_en    = 1'b1;
            S_LAST:   ;
            S_DECIDE: ;
            default:  ;
        endcase
    end

    // scan address counter, restarts with each request transaction
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = '0;
        else if (rd_en)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req.data;
        rd_idx_reg <= cnt_reg;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[sel_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[cnt_reg];
    end

    // the entry read last cycle is evaluated this cycle
    assign scan_ctl.clear     = accept;
    assign scan_ctl.eval      = rd_vld_reg;
    assign scan_ctl.idx       = rd_idx_reg;
    assign scan_ctl.entry_vld = valid_reg[rd_idx_reg];

    art_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .entry  (rd_data_reg),
        .key_ip (item_reg.ip_addr),
        .now_ms (item_reg.now_ms),
        .result (scan)
    );

    // matching entry first, then a free entry, otherwise the oldest one
    assign slot_idx     = scan.free_found ? scan.free_idx : scan.old_idx;
    assign sel_idx      = scan.match_found ? scan.match_idx : slot_idx;
    assign sel_valid    = valid_reg[sel_idx];
    assign sel_resolved = resolved_reg[sel_idx];
    assign sel_held     = held_reg[sel_idx];

    // decide step: result and write-back for the selected entry
    always_comb
    begin
        res                = '0;
        res.status         = ST_NONE;
        mem_we             = 1'b0;
        wr_data.ip         = item_reg.ip_addr;
        wr_data.mac        = item_reg.mac_addr;
        wr_data.stamp      = item_reg.now_ms;
        flag_we            = 1'b0;
        flag_valid         = sel_valid;
        flag_resolved      = sel_resolved;
        flag_held          = sel_held;
        if (item_reg.mode == MODE_UPDATE)
        begin
            if (scan.match_found || item_reg.create)
            begin
                mem_we            = 1'b1;
                flag_we           = 1'b1;
                flag_valid        = 1'b1;
                flag_resolved     = 1'b1;
                flag_held         = '0;
                res.status        = ST_UPDATED;
                res.entry_index   = IDX_OUT_W'(sel_idx);
                if (scan.match_found)
                    res.released_count = CNT_OUT_W'(sel_held);
                else if (sel_valid)
                    // evicted entry held packets for another address
                    res.dropped_count = CNT_OUT_W'(sel_held);
            end
        end
        else
        begin
            res.entry_index = IDX_OUT_W'(sel_idx);
            if (scan.match_found && sel_resolved)
            begin
                res.status  = ST_HIT;
                res.mac_out = scan.match_mac;
            end
            else if (scan.match_found)
            begin
                // pending entry: queue the packet, stamp kept
                res.status = ST_QUEUED;
                flag_we    = 1'b1;
                if (sel_held < HC_W'(HOLD_LIMIT))
                    flag_held = sel_held + 1'b1;
                else
                    res.hold_overflow = 1'b1;
            end
            else
            begin
                // miss: allocate a pending entry holding this packet
                res.status    = ST_QUEUED;
                mem_we        = 1'b1;
                flag_we       = 1'b1;
                flag_valid    = 1'b1;
                flag_resolved = 1'b0;
                flag_held     = HC_W'(1);
                if (sel_valid)
                    res.dropped_count = CNT_OUT_W'(sel_held);
            end
        end
        mem_we  = mem_we && res_load;
        flag_we = flag_we && res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            resolved_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                held_reg[i] <= '0;
        end
        else if (flag_we)
        begin
            valid_reg[sel_idx]    <= flag_valid;
            resolved_reg[sel_idx] <= flag_resolved;
            held_reg[sel_idx]     <= flag_held;
        end
    end

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            rsp_data_reg <= res;
    end

    assign req.ready = in_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

@@ hw/rtl/art_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the address resolution table, bound to the top level
// depends on art_pkg and address_resolution_table_core

module art_checker import art_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input art_rsp_t rsp_data
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed or dropped while stalled");

    // one item in flight: no new request right after a transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    // a new result only comes out of the busy phase
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared without a scan");

    // mac only on a lookup hit
    a_mac_hit_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_HIT |-> rsp_data.mac_out == '0)
        else $error("mac driven on a result other than a hit");

endmodule

bind address_resolution_table_core art_checker u_art_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
